// ===== rtl/julia_escape_time_pixel_unit_macros.svh =====
// assertion macros for the julia escape-time pixel unit
// used by the port checker; no other dependencies
`ifndef JULIA_ESCAPE_TIME_PIXEL_UNIT_MACROS_SVH
`define JULIA_ESCAPE_TIME_PIXEL_UNIT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define JET_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define JET_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/jet_pkg.sv =====
// shared types and constants for the julia escape-time pixel unit
// no dependencies
package jet_pkg;
  localparam int ZW = 32;
  localparam int CW = 24;
  localparam int LW = 8;
  localparam int TW = 16;
  localparam int SW = 13;

  // configuration register indexes
  localparam logic [2:0] REG_C_REAL    = 3'd0;
  localparam logic [2:0] REG_C_IMAG    = 3'd1;
  localparam logic [2:0] REG_LIMIT     = 3'd2;
  localparam logic [2:0] REG_THRESHOLD = 3'd3;
  localparam logic [2:0] REG_ROWS      = 3'd4;
  localparam logic [2:0] REG_COLS      = 3'd5;

  typedef enum logic [2:0] {
    BK_IDLE, BK_MUL, BK_ADD, BK_MAG, BK_CMP, BK_OUT
  } bk_state_t;

  typedef enum logic [1:0] {FR_IDLE, FR_DIV, FR_PUSH} fr_state_t;

  // start point of one pixel, passed through the queue
  typedef struct packed {
    logic signed [ZW-1:0] zr;
    logic signed [ZW-1:0] zi;
  } jet_point_t;

  function automatic logic signed [ZW-1:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[ZW-1:0];
  endfunction
endpackage

// ===== rtl/julia_escape_time_pixel_unit.sv =====
// julia escape-time pixel unit: front end divides, back end iterates
// a pixel passes through the front divider, the two-entry queue and the back-end iteration loop
// the front stalls input until its start point is queued, then divides the next pixel while the back end iterates
// a zero limit returns 0 without entering the iteration loop
// reset: synchronous active high; clears control and loads register defaults
// depends on jet_pkg, jet_front, jet_queue, jet_back
module julia_escape_time_pixel_unit #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS = 20
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [COORD_BITS-1:0] row,
  input  logic [COORD_BITS-1:0] col,
  output logic out_valid,
  input  logic out_stall,
  output logic [jet_pkg::LW-1:0] escape_count,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [23:0] cfg_data
);
  import jet_pkg::*;

  logic signed [CW-1:0] c_real, c_imag;
  logic [LW-1:0] iteration_limit;
  logic [TW-1:0] escape_threshold;
  logic [SW-1:0] image_rows, image_cols;
  logic fq_valid, fq_full, qb_valid, qb_take;
  jet_point_t fq_data, qb_data;
  logic zl_pend, bk_valid;
  logic [LW-1:0] bk_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      c_real <= -24'sd838861;
      c_imag <= 24'sd163578;
      iteration_limit <= 8'd200;
      escape_threshold <= 16'd1000;
      image_rows <= 13'd4000;
      image_cols <= 13'd4000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_C_REAL: c_real <= cfg_data;
        REG_C_IMAG: c_imag <= cfg_data;
        REG_LIMIT: iteration_limit <= cfg_data[LW-1:0];
        REG_THRESHOLD: escape_threshold <= cfg_data[TW-1:0];
        REG_ROWS: image_rows <= cfg_data[SW-1:0];
        REG_COLS: image_cols <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  jet_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .in_valid, .in_stall, .row, .col, .image_rows, .image_cols,
    .q_valid(fq_valid), .q_full(fq_full), .q_data(fq_data)
  );

  jet_queue u_queue (
    .clk, .rst, .wr_valid(fq_valid), .full(fq_full), .wr_data(fq_data),
    .rd_valid(qb_valid), .rd_take(qb_take || (zl_pend && !out_stall)), .rd_data(qb_data)
  );

  // zero limit transactions bypass the iteration loop
  assign zl_pend = qb_valid && (iteration_limit == '0) && !bk_valid;

  jet_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst, .q_valid(qb_valid && (iteration_limit != '0)), .q_take(qb_take),
    .q_data(qb_data), .c_real, .c_imag, .iteration_limit, .escape_threshold,
    .out_valid(bk_valid), .out_stall, .escape_count(bk_count)
  );

  assign out_valid = bk_valid || zl_pend;
  assign escape_count = bk_valid ? bk_count : '0;
endmodule

// ===== rtl/jet_front.sv =====
// front end: accepts a pixel and maps row and col to a start point by restoring division
// depends on jet_pkg
module jet_front #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS = 20
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [COORD_BITS-1:0] row,
  input  logic [COORD_BITS-1:0] col,
  input  logic [jet_pkg::SW-1:0] image_rows,
  input  logic [jet_pkg::SW-1:0] image_cols,
  output logic q_valid,
  input  logic q_full,
  output jet_pkg::jet_point_t q_data
);
  import jet_pkg::*;

  localparam int NW = COORD_BITS + 1 + FRAC_BITS;
  localparam int CNTW = $clog2(NW + 1);

  fr_state_t state, state_next;
  logic [NW-1:0] num_r, num_c, quo_r, quo_c;
  logic [SW:0] rem_r, rem_c;
  logic [SW-1:0] d_r, d_c;
  logic [CNTW-1:0] cnt;
  logic [SW:0] tr, tc;
  logic signed [NW+1:0] qr_s, qc_s;

  assign in_stall = (state != FR_IDLE);
  assign q_valid = (state == FR_PUSH);
  assign tr = {rem_r[SW-1:0], num_r[NW-1]};
  assign tc = {rem_c[SW-1:0], num_c[NW-1]};
  assign qr_s = $signed({2'b00, quo_r}) - ($signed(NW'(1)) <<< FRAC_BITS);
  assign qc_s = $signed({2'b00, quo_c}) - ($signed(NW'(1)) <<< FRAC_BITS);
  assign q_data.zr = sat32(66'(qr_s));
  assign q_data.zi = sat32(66'(qc_s));

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= FR_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      FR_IDLE: if (in_valid) state_next = FR_DIV;
      FR_DIV: if (cnt == CNTW'(NW - 1)) state_next = FR_PUSH;
      FR_PUSH: if (!q_full) state_next = FR_IDLE;
      default: state_next = FR_IDLE;
    endcase
  end

  // one quotient bit per cycle for both coordinates
  always_ff @(posedge clk) begin
    if (state == FR_IDLE && in_valid) begin
      num_r <= NW'({row, 1'b0}) << FRAC_BITS;
      num_c <= NW'({col, 1'b0}) << FRAC_BITS;
      d_r <= (image_rows == '0) ? SW'(1) : image_rows;
      d_c <= (image_cols == '0) ? SW'(1) : image_cols;
      rem_r <= '0;
      rem_c <= '0;
      cnt <= '0;
    end else if (state == FR_DIV) begin
      num_r <= num_r << 1;
      num_c <= num_c << 1;
      cnt <= cnt + 1'b1;
      if (tr >= {1'b0, d_r}) begin
        rem_r <= tr - {1'b0, d_r};
        quo_r <= {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= tr;
        quo_r <= {quo_r[NW-2:0], 1'b0};
      end
      if (tc >= {1'b0, d_c}) begin
        rem_c <= tc - {1'b0, d_c};
        quo_c <= {quo_c[NW-2:0], 1'b1};
      end else begin
        rem_c <= tc;
        quo_c <= {quo_c[NW-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== rtl/jet_queue.sv =====
// two-entry queue of start points between the front and back ends
// depends on jet_pkg
module jet_queue (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic full,
  input  jet_pkg::jet_point_t wr_data,
  output logic rd_valid,
  input  logic rd_take,
  output jet_pkg::jet_point_t rd_data
);
  import jet_pkg::*;

  jet_point_t mem [2];
  logic wp, rp;
  logic [1:0] count;
  logic do_wr, do_rd;

  assign full = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data = mem[rp];
  assign do_wr = wr_valid && !full;
  assign do_rd = rd_valid && rd_take;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= '0;
    end else begin
      if (do_wr) wp <= ~wp;
      if (do_rd) rp <= ~rp;
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) mem[wp] <= wr_data;
  end
endmodule

// ===== rtl/jet_back.sv =====
// back end: iterates z = z*z + c and counts until escape or limit
// depends on jet_pkg
module jet_back #(
  parameter int FRAC_BITS = 20
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_take,
  input  jet_pkg::jet_point_t q_data,
  input  logic signed [jet_pkg::CW-1:0] c_real,
  input  logic signed [jet_pkg::CW-1:0] c_imag,
  input  logic [jet_pkg::LW-1:0] iteration_limit,
  input  logic [jet_pkg::TW-1:0] escape_threshold,
  output logic out_valid,
  input  logic out_stall,
  output logic [jet_pkg::LW-1:0] escape_count
);
  import jet_pkg::*;

  bk_state_t state, state_next;
  logic signed [ZW-1:0] zr, zi;
  logic signed [63:0] rr, ii, ri;
  logic [63:0] mr, mi;
  logic [64:0] mag;
  logic [LW-1:0] k;
  logic signed [64:0] dr;
  logic signed [65:0] nr, ni;
  logic escaped;

  assign q_take = (state == BK_IDLE) && q_valid && (iteration_limit != '0);
  assign out_valid = (state == BK_OUT);
  assign dr = 65'(rr) - 65'(ii);
  assign nr = 66'(dr >>> FRAC_BITS) + 66'(c_real);
  assign ni = 66'(ri >>> (FRAC_BITS - 1)) + 66'(c_imag);
  // squared magnitude of the freshly updated point
  assign mag = {1'b0, mr} + {1'b0, mi};
  assign escaped = (mag[64:2*FRAC_BITS] > (65 - 2*FRAC_BITS)'(escape_threshold)) ||
                   ((mag[64:2*FRAC_BITS] == (65 - 2*FRAC_BITS)'(escape_threshold)) &&
                    (mag[2*FRAC_BITS-1:0] != '0));

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (q_valid) state_next = (iteration_limit == '0) ? BK_IDLE : BK_MUL;
      BK_MUL: state_next = BK_ADD;
      BK_ADD: state_next = BK_MAG;
      BK_MAG: state_next = BK_CMP;
      BK_CMP: begin
        if (escaped || (k + 1'b1 == iteration_limit)) state_next = BK_OUT;
        else state_next = BK_MUL;
      end
      BK_OUT: if (!out_stall) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // datapath: products, update with saturation, magnitude, count
  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        zr <= q_data.zr;
        zi <= q_data.zi;
        k <= '0;
      end
      BK_MUL: begin
        rr <= zr * zr;
        ii <= zi * zi;
        ri <= zr * zi;
      end
      BK_ADD: begin
        zr <= sat32(nr);
        zi <= sat32(ni);
      end
      BK_MAG: begin
        mr <= 64'(zr) * 64'(zr);
        mi <= 64'(zi) * 64'(zi);
      end
      BK_CMP: begin
        escape_count <= (escaped || (k + 1'b1 == iteration_limit)) ?
                        (escaped ? k : k + 1'b1) : k;
        k <= k + 1'b1;
      end
      default: ;
    endcase
  end
endmodule

// ===== rtl/jet_checker.sv =====
// port-level checker for the julia escape-time pixel unit, bound to the top level
// depends on julia_escape_time_pixel_unit_macros.svh
`include "julia_escape_time_pixel_unit_macros.svh"
module jet_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [7:0] escape_count
);
  // a stalled result holds
  `JET_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(escape_count))
  // an accepted pixel raises the input stall in the following cycle
  `JET_ASSERT_NEXT(a_in_busy, clk, rst, in_valid && !in_stall, in_stall)
  // no result right after reset
  `JET_ASSERT_NEXT(a_rst_quiet, clk, 1'b0, rst, !out_valid)
endmodule

bind julia_escape_time_pixel_unit jet_checker u_jet_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .escape_count
);

// ===== verif/tb.sv =====
// testbench for the julia escape-time pixel unit: self-checking, random handshake idling
// depends on jet_pkg and julia_escape_time_pixel_unit
`timescale 1ns / 1ps

module tb;
  import jet_pkg::*;

  localparam int FRAC = 20;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct {
    logic [11:0] row;
    logic [11:0] col;
  } pixel_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [11:0] row;
  logic [11:0] col;
  logic out_valid;
  logic out_stall;
  logic [LW-1:0] escape_count;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [23:0] cfg_data;

  julia_escape_time_pixel_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .row(row), .col(col),
    .out_valid(out_valid), .out_stall(out_stall), .escape_count(escape_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // mirrored register file
  logic signed [CW-1:0] c_re;
  logic signed [CW-1:0] c_im;
  logic [LW-1:0] iter_lim;
  logic [TW-1:0] thresh;
  logic [SW-1:0] n_rows;
  logic [SW-1:0] n_cols;

  pixel_t pixel_q[$];
  logic [LW-1:0] count_q[$];
  int errors = 0;
  int cycles = 0;
  bit idle_on = 1;
  bit hold_req = 0;
  bit took = 0;
  int send_gap = 0;
  int stall_left = 0;

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint start_point(logic [11:0] idx, logic [SW-1:0] size);
    longint num;
    longint d;
    num = longint'(idx) * 2 * (64'sd1 <<< FRAC);
    d = (size == 0) ? 1 : longint'(size);
    return clamp32(num / d - (64'sd1 <<< FRAC));
  endfunction

  // escape-time count of one pixel under the mirrored registers
  function automatic logic [LW-1:0] escape_of(logic [11:0] r, logic [11:0] c);
    longint zr;
    longint zi;
    longint nr;
    longint ni;
    logic [63:0] mag;
    logic [63:0] whole;
    int k;
    zr = start_point(r, n_rows);
    zi = start_point(c, n_cols);
    for (k = 0; k < iter_lim; k++) begin
      nr = clamp32(((zr * zr - zi * zi) >>> FRAC) + longint'(c_re));
      ni = clamp32(((zr * zi) >>> (FRAC - 1)) + longint'(c_im));
      zr = nr;
      zi = ni;
      mag = 64'(zr * zr) + 64'(zi * zi);
      whole = mag >> (2 * FRAC);
      if (whole > thresh || (whole == thresh && mag[2*FRAC-1:0] != 0)) break;
    end
    return k[LW-1:0];
  endfunction

  // input side: sample accepted transactions, queue their expected counts
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && in_valid && !in_stall) begin
      count_q.push_back(escape_of(row, col));
      took = 1;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("FAIL");
      $finish;
    end
  end

  // output side: compare against oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (count_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %0d", $time, escape_count);
        errors++;
      end else begin
        if (escape_count !== count_q[0]) begin
          $display("%0t escape_count mismatch: expected %0d, actual %0d",
                   $time, count_q[0], escape_count);
          errors++;
        end
        void'(count_q.pop_front());
      end
    end
  end

  // pixel driver with random gaps
  always @(negedge clk) begin
    pixel_t p;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || took) begin
      took = 0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        p = pixel_q.pop_front();
        row <= p.row;
        col <= p.col;
        in_valid <= 1'b1;
        if (idle_on && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 14);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall bursts, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      stall_left = 3000;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 13);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic write_reg(logic [2:0] idx, int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 24'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_C_REAL:    c_re = CW'(val);
      REG_C_IMAG:    c_im = CW'(val);
      REG_LIMIT:     iter_lim = LW'(val);
      REG_THRESHOLD: thresh = TW'(val);
      REG_ROWS:      n_rows = SW'(val);
      REG_COLS:      n_cols = SW'(val);
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pixel_q.size() > 0 || count_q.size() > 0 || in_valid) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic add_pixel(int r, int c);
    pixel_t p;
    p.row = 12'(r);
    p.col = 12'(c);
    pixel_q.push_back(p);
  endtask

  function automatic int pick_coord(logic [SW-1:0] size);
    int top;
    top = (size == 0) ? 0 : ((size > 4096) ? 4095 : size - 1);
    if ($urandom_range(0, 4) == 0) return int'($urandom_range(0, 4095));
    return int'($urandom_range(0, top));
  endfunction

  function automatic logic [23:0] pick_c();
    if ($urandom_range(0, 3) == 0) return 24'($urandom);
    return 24'(int'($urandom_range(0, 3145728)) - 1572864);
  endfunction

  initial begin
    int n;
    rst = 1'b1;
    in_valid = 1'b0;
    row = '0;
    col = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    c_re = -24'sd838861;
    c_im = 24'sd163578;
    iter_lim = 8'd200;
    thresh = 16'd1000;
    n_rows = 13'd4000;
    n_cols = 13'd4000;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset settings, corners, indices past the image edge
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    add_pixel(0, 4095);
    add_pixel(4095, 0);
    add_pixel(2000, 2000);
    add_pixel(1999, 2001);
    add_pixel(3999, 3999);
    add_pixel(4000, 1000);
    add_pixel(12'haaa, 12'h555);
    add_pixel(12'h555, 12'haaa);
    drain();
    // zero limit, ignored register indexes, zero image size
    write_reg(REG_LIMIT, 0);
    write_reg(3'd6, 24'hffffff);
    write_reg(3'd7, 24'h000001);
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    drain();
    write_reg(REG_LIMIT, 30);
    write_reg(REG_ROWS, 0);
    write_reg(REG_COLS, 0);
    add_pixel(0, 0);
    add_pixel(1, 1);
    add_pixel(4095, 2);
    add_pixel(3, 4095);
    drain();

    // random phases, each with its own register setting
    for (int ph = 0; ph < 14; ph++) begin
      write_reg(REG_C_REAL, pick_c());
      write_reg(REG_C_IMAG, pick_c());
      write_reg(REG_LIMIT, $urandom_range(1, 40));
      write_reg(REG_THRESHOLD, ($urandom_range(0, 2) == 0) ? $urandom_range(1, 65535)
                                                             : $urandom_range(1, 16));
      write_reg(REG_ROWS, $urandom_range(1, 4096));
      write_reg(REG_COLS, $urandom_range(1, 4096));
      n = 100;
      case (ph)
        0: begin
          write_reg(REG_C_REAL, 24'h800000);
          write_reg(REG_C_IMAG, 24'h7fffff);
          write_reg(REG_THRESHOLD, 1);
          write_reg(REG_ROWS, 4096);
          write_reg(REG_COLS, 1);
        end
        1: begin
          write_reg(REG_C_REAL, 24'h7fffff);
          write_reg(REG_C_IMAG, 24'h800000);
          write_reg(REG_THRESHOLD, 65535);
          write_reg(REG_ROWS, 1);
          write_reg(REG_COLS, 4096);
          write_reg(REG_LIMIT, 1);
        end
        5: begin
          write_reg(REG_LIMIT, 255);
          n = 15;
        end
        13: idle_on = 0;
        default: ;
      endcase
      for (int i = 0; i < n; i++) add_pixel(pick_coord(n_rows), pick_coord(n_cols));
      if (ph == 2) hold_req = 1;
      drain();
    end

    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
